### src/cnt_pkg.sv
// ----------------------------------------------------------------------------
// Compacting name table package
// Shared types, codes and defaults for the name table and its cells.
// ----------------------------------------------------------------------------
package cnt_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_LIST   = 2'd2;

    typedef enum logic [2:0] {
        ST_CREATED    = 3'd0,
        ST_FULL       = 3'd1,
        ST_DELETED    = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_LIST_ENTRY = 3'd4,
        ST_LIST_EMPTY = 3'd5
    } t_status;

    typedef struct packed {
        logic [63:0] name_a;
        logic [63:0] name_b;
        logic [31:0] name_c;
    } t_name;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] name_a;
        logic [63:0] name_b;
        logic [31:0] name_c;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [63:0] out_name_a;
        logic [63:0] out_name_b;
        logic [31:0] out_name_c;
        logic [5:0]  occupancy;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_WRAP
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

endpackage

### src/cnt_cell.sv
// ----------------------------------------------------------------------------
// Name table cell
// Holds one stored name, loads, shifts or wraps it, and registers a match.
// ----------------------------------------------------------------------------
module cnt_cell (
    input  logic              i_clk,
    input  cnt_pkg::t_cell_op i_op,
    input  cnt_pkg::t_name    i_load,
    input  cnt_pkg::t_name    i_up,
    input  cnt_pkg::t_name    i_wrap,
    input  cnt_pkg::t_name    i_key,
    input  logic              i_cmp_en,
    output cnt_pkg::t_name    o_name,
    output logic              o_match
);
    import cnt_pkg::*;

    t_name r_name;
    logic  r_match;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_LOAD:  r_name <= i_load;
            CELL_SHIFT: r_name <= i_up;
            CELL_WRAP:  r_name <= i_wrap;
            default:    r_name <= r_name;
        endcase
        if (i_cmp_en) begin
            r_match <= (r_name == i_key);
        end
    end

    assign o_name  = r_name;
    assign o_match = r_match;

endmodule

### src/compacting_name_table_top.sv
// ----------------------------------------------------------------------------
// Compacting name table
// Create and delete: the request is registered, then S_EXEC registers the result in
// the output stage once it is free. No new request is taken until the table
// is idle again; a list sends one entry per stored name, paced by the output stage.
// The row of cells rotates one place per listed name.
// Reset clears the entry count and the control state; names are not cleared.
// ----------------------------------------------------------------------------
module compacting_name_table_top #(
    parameter int CAPACITY = cnt_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cnt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cnt_pkg::t_out_item o_out_item
);
    import cnt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    t_in_item    r_req;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_name       key;
    t_name       req_name;
    t_name       cell_name [CAPACITY];
    t_cell_op    cell_op [CAPACITY];
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] hit;
    logic [CAPACITY-1:0] pre;

    logic accept;
    logic out_free;
    logic do_create;
    logic do_delete;
    logic do_rotate;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign key      = '{name_a: i_in_item.name_a, name_b: i_in_item.name_b,
                        name_c: i_in_item.name_c};
    assign req_name = '{name_a: r_req.name_a, name_b: r_req.name_b,
                        name_c: r_req.name_c};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_name up;
        if (g == CAPACITY - 1) begin : g_top
            assign up = cell_name[g];
        end else begin : g_mid
            assign up = cell_name[g+1];
        end
        cnt_cell u_cell (
            .i_clk    (i_clk),
            .i_op     (cell_op[g]),
            .i_load   (req_name),
            .i_up     (up),
            .i_wrap   (cell_name[0]),
            .i_key    (key),
            .i_cmp_en (accept),
            .o_name   (cell_name[g]),
            .o_match  (match[g])
        );
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit[i] = match[i] && (CW'(i) < r_count);
        end
        pre[0] = hit[0];
        for (int i = 1; i < CAPACITY; i++) begin
            pre[i] = pre[i-1] | hit[i];
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_op[i] = CELL_HOLD;
            if (do_create && CW'(i) == r_count) begin
                cell_op[i] = CELL_LOAD;
            end else if (do_delete && pre[i]) begin
                cell_op[i] = CELL_SHIFT;
            end else if (do_rotate) begin
                cell_op[i] = (CW'(i + 1) == r_count) ? CELL_WRAP : CELL_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_item;
        end
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = (r_state != S_IDLE);
        do_create   = 1'b0;
        do_delete   = 1'b0;
        do_rotate   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state            = S_IDLE;
                    n_out              = '0;
                    n_out.last         = 1'b1;
                    unique case (r_req.func)
                        FUNC_CREATE: begin
                            if (r_count < CW'(CAPACITY)) begin
                                do_create = 1'b1;
                                n_count   = r_count + 1'b1;
                                n_out.status = ST_CREATED;
                            end else begin
                                n_out.status = ST_FULL;
                            end
                            n_out_valid = 1'b1;
                        end
                        FUNC_DELETE: begin
                            if (pre[CAPACITY-1]) begin
                                do_delete    = 1'b1;
                                n_count      = r_count - 1'b1;
                                n_out.status = ST_DELETED;
                            end else begin
                                n_out.status = ST_NOT_FOUND;
                            end
                            n_out_valid = 1'b1;
                        end
                        FUNC_LIST: begin
                            if (r_count == '0) begin
                                n_out.status = ST_LIST_EMPTY;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_state = S_LIST;
                                n_left  = r_count;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.occupancy = 6'(n_count);
                end
            end
            S_LIST: begin
                if (out_free) begin
                    do_rotate        = 1'b1;
                    n_left           = r_left - 1'b1;
                    n_out_valid      = 1'b1;
                    n_out.status     = ST_LIST_ENTRY;
                    n_out.out_name_a = cell_name[0].name_a;
                    n_out.out_name_b = cell_name[0].name_b;
                    n_out.out_name_c = cell_name[0].name_c;
                    n_out.occupancy  = 6'(r_count);
                    n_out.last       = (r_left == CW'(1));
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
